// ===== sv/utf8_greedy_line_fit_top_defines.svh =====
// Assertion macros shared by the port checker of the line fitter.
`ifndef UTF8_GREEDY_LINE_FIT_TOP_DEFINES_SVH
`define UTF8_GREEDY_LINE_FIT_TOP_DEFINES_SVH

// Check a condition in the cycle after a trigger, reset included.
`define UGL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("line fitter port check failed");

// Check a condition in the cycle after a trigger, outside reset.
`define UGL_ASSERT_RUN(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("line fitter port check failed");

`endif

// ===== sv/ugl_pkg.sv =====
// Shared types, constants and the accent folding function of the line fitter.
package ugl_pkg;

  // Storage sizes
  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int POS_BITS    = 16;
  localparam int CNT_W       = 16;
  // Event queue depth, a power of two
  localparam int EVQ_DEPTH   = 4;
  localparam int EVQ_AW      = $clog2(EVQ_DEPTH);

  // Input operations
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // End reasons
  localparam logic [1:0] REASON_NEWLINE  = 2'd0;
  localparam logic [1:0] REASON_OVERFLOW = 2'd1;
  localparam logic [1:0] REASON_END      = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_MODE = 3'd5;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;

  typedef struct packed {
    logic        op;
    logic [7:0]  text_byte;
    logic        is_last;
    logic [7:0]  table_index;
    logic [15:0] glyph_width;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]   char_count;
    logic signed [23:0] line_width;
    logic [1:0]         end_reason;
  } out_word_t;

  typedef struct packed {
    logic [22:0]        max_width;
    logic [15:0]        scale;
    logic signed [15:0] spacing;
    logic [15:0]        size;
    logic [15:0]        stretch;
    logic               word_mode;
  } cfg_t;

  // Events from the decoder to the width engine
  typedef enum logic [1:0] {
    EV_LOAD,
    EV_CHAR,
    EV_NUL,
    EV_NL
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic        last;
    logic        two_byte;
    logic [7:0]  code;
    logic [15:0] wdata;
  } ev_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL0,
    B_MUL1,
    B_MUL2,
    B_APPLY,
    B_EMIT
  } back_state_t;

  // Fold an accented code point to its base letter
  function automatic logic [7:0] base_of(input logic [10:0] cp, input logic [7:0] fallback);
    logic [7:0] base;
    unique case (cp)
      11'h0E4, 11'h105, 11'h0E0: base = "a";
      11'h0C4, 11'h104, 11'h0C0: base = "A";
      11'h0F6, 11'h0F3, 11'h0F2: base = "o";
      11'h0D6, 11'h0D3, 11'h0D2: base = "O";
      11'h0FC, 11'h0F9:          base = "u";
      11'h0DC, 11'h0D9:          base = "U";
      11'h106:                   base = "C";
      11'h107:                   base = "c";
      11'h118, 11'h0C8:          base = "E";
      11'h119, 11'h0E8:          base = "e";
      11'h141:                   base = "L";
      11'h142:                   base = "l";
      11'h143:                   base = "N";
      11'h144:                   base = "n";
      11'h15A:                   base = "S";
      11'h15B:                   base = "s";
      11'h179, 11'h17B:          base = "Z";
      11'h17A, 11'h17C:          base = "z";
      11'h0CC:                   base = "I";
      11'h0EC:                   base = "i";
      default:                   base = fallback;
    endcase
    return base;
  endfunction

endpackage

// ===== sv/utf8_greedy_line_fit_top.sv =====
// A character passes a table read, three multiply stages and accumulate; a table load or
// control byte needs only the idle state. A posted result then goes through the emit state,
// which stalls while the output holds an unread result. One event is handled at a time,
// behind a 4-deep queue; a lead byte then a non-continuation non-lead byte gives two events.
// Reset (synchronous, active low) clears text state, queues and registers to defaults;
// the glyph width table is not cleared and must be loaded before use.
module utf8_greedy_line_fit_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  ugl_pkg::in_word_t                in_word,
  output logic                             out_empty,
  input  logic                             out_pop,
  output ugl_pkg::out_word_t               out_word,
  input  logic                             cfg_we,
  input  logic [ugl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ugl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  ugl_pkg::cfg_t cfg_r;
  logic          ev_push, ev_full, ev_pop, ev_empty;
  ugl_pkg::ev_t  ev_in, ev_head;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_width <= '0;
      cfg_r.scale     <= 16'd256;
      cfg_r.spacing   <= '0;
      cfg_r.size      <= 16'd256;
      cfg_r.stretch   <= 16'd4096;
      cfg_r.word_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ugl_pkg::CFG_MAX_WIDTH: cfg_r.max_width <= cfg_wdata;
        ugl_pkg::CFG_SCALE:     cfg_r.scale     <= cfg_wdata[15:0];
        ugl_pkg::CFG_SPACING:   cfg_r.spacing   <= $signed(cfg_wdata[15:0]);
        ugl_pkg::CFG_SIZE:      cfg_r.size      <= cfg_wdata[15:0];
        ugl_pkg::CFG_STRETCH:   cfg_r.stretch   <= cfg_wdata[15:0];
        ugl_pkg::CFG_WORD_MODE: cfg_r.word_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  ugl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .ev_push (ev_push),
    .ev_data (ev_in),
    .ev_full (ev_full)
  );

  ugl_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev_in),
    .full      (ev_full),
    .pop       (ev_pop),
    .head      (ev_head),
    .empty     (ev_empty)
  );

  ugl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ev_empty  (ev_empty),
    .ev_pop    (ev_pop),
    .ev_data   (ev_head),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ===== sv/ugl_evq.sv =====
// Event queue between the byte decoder and the width engine.
module ugl_evq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ugl_pkg::ev_t push_data,
  output logic         full,
  input  logic         pop,
  output ugl_pkg::ev_t head,
  output logic         empty
);

  localparam int Aw = ugl_pkg::EVQ_AW;

  ugl_pkg::ev_t  slot_r [ugl_pkg::EVQ_DEPTH];
  logic [Aw-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Aw-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Aw:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (Aw+1)'(ugl_pkg::EVQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/ugl_front.sv =====
// Byte decoder: pairs UTF-8 sequences, folds accents and classifies bytes into events.
module ugl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ugl_pkg::cfg_t     cfg,
  input  logic              in_push,
  output logic              in_full,
  input  ugl_pkg::in_word_t in_word,
  output logic              ev_push,
  output ugl_pkg::ev_t      ev_data,
  input  logic              ev_full
);

  logic         pend_v_r, pend_v_nxt;
  logic [7:0]   pend_b_r, pend_b_nxt;
  logic         hold_v_r, hold_v_nxt;
  ugl_pkg::ev_t hold_ev_r, hold_ev_nxt;

  logic         in_acc;
  logic [7:0]   b;
  logic         last;
  logic         is_cont;
  logic         nb_has, nb_pend;
  ugl_pkg::ev_t nb_ev;
  logic         has0, has1;
  ugl_pkg::ev_t ev0, ev1;

  function automatic ugl_pkg::ev_t mk_ev(input ugl_pkg::ev_kind_t kind, input logic [7:0] code,
                                         input logic two, input logic lst,
                                         input logic [15:0] w);
    ugl_pkg::ev_t e;
    e.kind     = kind;
    e.last     = lst;
    e.two_byte = two;
    e.code     = code;
    e.wdata    = w;
    return e;
  endfunction

  assign in_full = hold_v_r || ev_full;
  assign in_acc  = in_push && !in_full;
  assign b       = in_word.text_byte;
  assign last    = in_word.is_last;
  assign is_cont = (b != ugl_pkg::CH_NUL) && (b[7:6] == 2'b10);

  // Classify the new byte on its own
  always_comb begin
    nb_has  = 1'b1;
    nb_pend = 1'b0;
    nb_ev   = mk_ev(ugl_pkg::EV_CHAR, ugl_pkg::base_of({3'b000, b}, b), 1'b0, last, '0);
    priority if (b == ugl_pkg::CH_NUL) begin
      nb_ev = mk_ev(ugl_pkg::EV_NUL, b, 1'b0, last, '0);
    end else if (cfg.word_mode && (b == ugl_pkg::CH_LF || b == ugl_pkg::CH_CR)) begin
      nb_ev = mk_ev(ugl_pkg::EV_NL, b, 1'b0, last, '0);
    end else if ((b[7:5] == 3'b110) && !last) begin
      nb_has  = 1'b0;
      nb_pend = 1'b1;
    end else begin
      nb_has = 1'b1;
    end
  end

  // Combine with a waiting lead byte and feed the queue
  always_comb begin
    has0        = 1'b0;
    has1        = 1'b0;
    ev0         = nb_ev;
    ev1         = nb_ev;
    pend_v_nxt  = pend_v_r;
    pend_b_nxt  = pend_b_r;
    hold_v_nxt  = hold_v_r;
    hold_ev_nxt = hold_ev_r;

    if (in_acc) begin
      priority if (in_word.op == ugl_pkg::OP_LOAD) begin
        ev0  = mk_ev(ugl_pkg::EV_LOAD, in_word.table_index, 1'b0, 1'b0, in_word.glyph_width);
        has0 = 1'b1;
      end else if (pend_v_r && is_cont) begin
        ev0 = mk_ev(ugl_pkg::EV_CHAR,
                    ugl_pkg::base_of({pend_b_r[4:0], b[5:0]}, pend_b_r), 1'b1, last, '0);
        has0       = 1'b1;
        pend_v_nxt = 1'b0;
      end else if (pend_v_r) begin
        // Lead byte without continuation: size it as Latin-1, then the new byte
        ev0 = mk_ev(ugl_pkg::EV_CHAR,
                    ugl_pkg::base_of({3'b000, pend_b_r}, pend_b_r), 1'b0, 1'b0, '0);
        has0       = 1'b1;
        ev1        = nb_ev;
        has1       = nb_has;
        pend_v_nxt = nb_pend;
        pend_b_nxt = b;
      end else begin
        ev0        = nb_ev;
        has0       = nb_has;
        pend_v_nxt = nb_pend;
        pend_b_nxt = b;
      end
    end

    if (hold_v_r) begin
      ev_push    = !ev_full;
      ev_data    = hold_ev_r;
      hold_v_nxt = ev_full;
    end else begin
      ev_push = in_acc && has0;
      ev_data = ev0;
      if (in_acc && has1) begin
        hold_v_nxt  = 1'b1;
        hold_ev_nxt = ev1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
    pend_b_r  <= pend_b_nxt;
    hold_ev_r <= hold_ev_nxt;
  end

endmodule

// ===== sv/ugl_back.sv =====
// Width engine: glyph table, fixed-point width scaling, line accumulation and results.
module ugl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ugl_pkg::cfg_t      cfg,
  input  logic               ev_empty,
  output logic               ev_pop,
  input  ugl_pkg::ev_t       ev_data,
  output logic               out_empty,
  input  logic               out_pop,
  output ugl_pkg::out_word_t out_word
);

  localparam int PosW = ugl_pkg::POS_BITS;
  localparam int CntW = ugl_pkg::CNT_W;
  localparam int Aw   = ugl_pkg::TBL_AW;
  localparam logic signed [33:0] AccMax = 34'sd8388607;
  localparam logic signed [33:0] AccMin = -34'sd8388608;

  ugl_pkg::back_state_t state_r, state_nxt;
  ugl_pkg::ev_t         ev_r, ev_nxt;
  logic [31:0]          p0_r, p0_nxt;
  logic signed [50:0]   p1_r, p1_nxt;
  logic signed [51:0]   p2_r, p2_nxt;
  logic signed [23:0]   acc_r, acc_nxt;
  logic signed [23:0]   bw_r, bw_nxt;
  logic [PosW-1:0]      bc_r, bc_nxt;
  logic [PosW-1:0]      bp_r, bp_nxt;
  logic                 done_r, done_nxt;
  ugl_pkg::out_word_t   res_r, res_nxt;
  logic                 out_v_r, out_v_nxt;
  ugl_pkg::out_word_t   out_word_r, out_word_nxt;

  logic [15:0]          width_mem [ugl_pkg::TABLE_DEPTH];
  logic [15:0]          rd_q_r;
  logic                 mem_we, mem_re;

  logic                 oor_in, oor_cur;
  logic signed [33:0]   t_w;
  logic signed [50:0]   rnd1_w;
  logic signed [34:0]   t2_w;
  logic signed [51:0]   rnd2_w;
  logic signed [31:0]   cw_w;
  logic signed [33:0]   sum_w;
  logic signed [23:0]   sat_w;
  logic                 ovf_w, brk_w;
  logic [PosW-1:0]      pos_after_w, bc_new_w;
  logic signed [23:0]   bw_new_w;
  logic                 got, fin_last;

  function automatic logic [PosW-1:0] pos_add(input logic [PosW-1:0] a, input logic [1:0] inc);
    logic [PosW:0] s;
    s = {1'b0, a} + {{(PosW-1){1'b0}}, inc};
    return s[PosW] ? {PosW{1'b1}} : s[PosW-1:0];
  endfunction

  function automatic ugl_pkg::out_word_t mk_res(input logic [PosW-1:0] cnt,
                                                input logic signed [23:0] w,
                                                input logic [1:0] why);
    ugl_pkg::out_word_t r;
    r.char_count = CntW'(cnt);
    r.line_width = w;
    r.end_reason = why;
    return r;
  endfunction

  // Glyph codes beyond the table have no width
  assign oor_in  = ({1'b0, ev_data.code} >= 9'(ugl_pkg::TABLE_DEPTH));
  assign oor_cur = ({1'b0, ev_r.code} >= 9'(ugl_pkg::TABLE_DEPTH));

  // Width datapath: raw*scale + spacing, times size, round, times stretch, round
  assign t_w    = $signed({2'b00, p0_r}) + $signed({{2{cfg.spacing[15]}}, cfg.spacing, 16'h0000});
  assign rnd1_w = p1_r + 51'sd32768;
  assign t2_w   = $signed(rnd1_w[50:16]);
  assign rnd2_w = p2_r + 52'sd524288;
  assign cw_w   = oor_cur ? 32'sd0 : $signed(rnd2_w[51:20]);
  assign sum_w  = $signed({{10{acc_r[23]}}, acc_r}) + $signed({{2{cw_w[31]}}, cw_w});
  assign ovf_w  = sum_w > $signed({11'b0, cfg.max_width});

  // Saturate the running width
  always_comb begin
    priority if (sum_w > AccMax) begin
      sat_w = 24'sh7FFFFF;
    end else if (sum_w < AccMin) begin
      sat_w = 24'sh800000;
    end else begin
      sat_w = sum_w[23:0];
    end
  end

  // Break points and positions for the current character
  assign brk_w = cfg.word_mode && (ev_r.code == ugl_pkg::CH_SPACE ||
                                   ev_r.code == ugl_pkg::CH_TAB ||
                                   ev_r.code == ugl_pkg::CH_HYPHEN);
  assign pos_after_w = pos_add(bp_r, ev_r.two_byte ? 2'd2 : 2'd1);
  assign bc_new_w    = brk_w ? pos_after_w : bc_r;
  assign bw_new_w    = brk_w ? acc_r : bw_r;

  // Sequence one event at a time
  always_comb begin
    state_nxt    = state_r;
    ev_nxt       = ev_r;
    p0_nxt       = p0_r;
    p1_nxt       = p1_r;
    p2_nxt       = p2_r;
    acc_nxt      = acc_r;
    bw_nxt       = bw_r;
    bc_nxt       = bc_r;
    bp_nxt       = bp_r;
    done_nxt     = done_r;
    res_nxt      = res_r;
    out_v_nxt    = out_v_r;
    out_word_nxt = out_word_r;
    ev_pop       = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    got          = 1'b0;
    fin_last     = ev_r.last;

    if (out_pop && out_v_r) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      ugl_pkg::B_IDLE: begin
        fin_last = ev_data.last;
        if (!ev_empty) begin
          ev_pop = 1'b1;
          ev_nxt = ev_data;
          priority if (ev_data.kind == ugl_pkg::EV_LOAD) begin
            mem_we = !oor_in;
          end else if (done_r) begin
            // Swallow text up to the last word
            if (ev_data.last) begin
              acc_nxt  = '0;
              bw_nxt   = '0;
              bc_nxt   = '0;
              bp_nxt   = '0;
              done_nxt = 1'b0;
            end
          end else if (ev_data.kind == ugl_pkg::EV_CHAR) begin
            mem_re    = 1'b1;
            state_nxt = ugl_pkg::B_MUL0;
          end else if (ev_data.kind == ugl_pkg::EV_NUL) begin
            got     = 1'b1;
            res_nxt = mk_res(bp_r, acc_r, ugl_pkg::REASON_END);
          end else begin
            got     = 1'b1;
            res_nxt = mk_res(pos_add(bp_r, 2'd1), acc_r, ugl_pkg::REASON_NEWLINE);
          end
        end
      end
      ugl_pkg::B_MUL0: begin
        p0_nxt    = {16'h0000, rd_q_r} * {16'h0000, cfg.scale};
        state_nxt = ugl_pkg::B_MUL1;
      end
      ugl_pkg::B_MUL1: begin
        p1_nxt    = 51'(t_w) * 51'($signed({1'b0, cfg.size}));
        state_nxt = ugl_pkg::B_MUL2;
      end
      ugl_pkg::B_MUL2: begin
        p2_nxt    = 52'(t2_w) * 52'($signed({1'b0, cfg.stretch}));
        state_nxt = ugl_pkg::B_APPLY;
      end
      ugl_pkg::B_APPLY: begin
        state_nxt = ugl_pkg::B_IDLE;
        bc_nxt    = bc_new_w;
        bw_nxt    = bw_new_w;
        bp_nxt    = pos_after_w;
        if (ovf_w) begin
          got = 1'b1;
          if (cfg.word_mode && (bc_new_w != '0)) begin
            res_nxt = mk_res(bc_new_w, bw_new_w, ugl_pkg::REASON_OVERFLOW);
          end else begin
            res_nxt = mk_res(bp_r, acc_r, ugl_pkg::REASON_OVERFLOW);
          end
        end else begin
          acc_nxt = sat_w;
          if (ev_r.last) begin
            got     = 1'b1;
            res_nxt = mk_res(pos_after_w, sat_w, ugl_pkg::REASON_END);
          end
        end
      end
      ugl_pkg::B_EMIT: begin
        if (!out_v_r || out_pop) begin
          out_v_nxt    = 1'b1;
          out_word_nxt = res_r;
          state_nxt    = ugl_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = ugl_pkg::B_IDLE;
      end
    endcase

    // Close the line: clear on the last word, else swallow the rest
    if (got) begin
      state_nxt = ugl_pkg::B_EMIT;
      if (fin_last) begin
        acc_nxt  = '0;
        bw_nxt   = '0;
        bc_nxt   = '0;
        bp_nxt   = '0;
        done_nxt = 1'b0;
      end else begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ugl_pkg::B_IDLE;
      acc_r   <= '0;
      bw_r    <= '0;
      bc_r    <= '0;
      bp_r    <= '0;
      done_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      bw_r    <= bw_nxt;
      bc_r    <= bc_nxt;
      bp_r    <= bp_nxt;
      done_r  <= done_nxt;
      out_v_r <= out_v_nxt;
    end
    ev_r       <= ev_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  // Glyph width table, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      width_mem[ev_data.code[Aw-1:0]] <= ev_data.wdata;
    end
    if (mem_re) begin
      rd_q_r <= width_mem[ev_data.code[Aw-1:0]];
    end
  end

  assign out_empty = !out_v_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/ugl_port_chk.sv =====
// Port-level checker for the line fitter, bound to the top level.
`include "utf8_greedy_line_fit_top_defines.svh"

module ugl_port_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input ugl_pkg::out_word_t out_word
);

  // Reset drops any posted result and opens the input
  `UGL_ASSERT_NEXT(a_reset_out_empty, !rst_n, out_empty)
  `UGL_ASSERT_NEXT(a_reset_in_open, !rst_n, !in_full)

  // Input side fills only after a word was offered
  `UGL_ASSERT_RUN(a_full_needs_push, !in_full && !in_push, !in_full)

  // A stalled result holds
  `UGL_ASSERT_RUN(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_word))

endmodule

bind utf8_greedy_line_fit_top ugl_port_chk u_port_chk (.*);
